[rtl/core/mbda_pkg.sv]
// Shared types, codes and constants of the multi-bin DFT accumulator.
// Used by the top level and the checker; depends on nothing.
package mbda_pkg;

  localparam int POINTS_DEF    = 1024;
  localparam int BINS_DEF      = 4;
  localparam int TRIG_BITS_DEF = 16;

  localparam logic [10:0] POINT_COUNT_RST  = 11'd1024;
  localparam logic [2:0]  BIN_COUNT_RST    = 3'd4;
  localparam logic [15:0] SAMPLE_COUNT_RST = 16'd1;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_POINT_COUNT  = 3'd0;
  localparam logic [2:0] REG_BIN_COUNT    = 3'd1;
  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd2;
  localparam logic [2:0] REG_FREQ_0       = 3'd3;
  localparam logic [2:0] REG_FREQ_1       = 3'd4;
  localparam logic [2:0] REG_FREQ_2       = 3'd5;
  localparam logic [2:0] REG_FREQ_3       = 3'd6;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PHASE, ST_LATCH, ST_FOLD, ST_SQ, ST_Z2, ST_HMUL,
    ST_HACC, ST_SR, ST_ROUND, ST_PRE, ST_PIM, ST_WRITE, ST_RD, ST_RDW,
    ST_DRE, ST_DIM
  } mbda_state_t;

  typedef enum logic [2:0] {
    MUL_PHASE, MUL_SQ, MUL_HORNER, MUL_SR, MUL_RE, MUL_IM
  } mbda_mul_sel_t;

  // Odd Taylor coefficients of sin(pi/2 z) in Q30.
  function automatic logic signed [32:0] sin_coef(input logic [2:0] k);
    logic signed [32:0] c;
    case (k)
      3'd0:    c = 33'sd1686629713;
      3'd1:    c = 33'sd693598668;
      3'd2:    c = 33'sd85569306;
      3'd3:    c = 33'sd5026995;
      3'd4:    c = 33'sd172272;
      default: c = 33'sd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/multi_bin_dft_accumulator.sv]
// Top level of the multi-bin DFT accumulator: sequencer, shared multiplier, store.
// Depends on mbda_pkg and mbda_divider.
//
//  channel  | handshake            | payload
//  input    | start, busy          | in_operation, in_vertex, in_bin_select, in_sample,
//           |                      | in_sample_time
//  result   | out_valid (strobe)   | out_real_sum, out_imag_sum, out_read_vertex, out_read_bin
//  config   | psel, penable, pready| pwrite, paddr, pwdata, prdata
//
// Per bin in use, an accumulate runs the one shared 33x33 multiplier for the phase,
// the Horner sine steps for cosine and sine, and the two products.
// A read runs the 1-bit-per-cycle divider twice.
// A clear, and the pass after reset, sweeps all POINTS*BINS entries of the store.
// Results are strobed for one cycle; the receiver cannot stall, and busy holds off inputs.
module multi_bin_dft_accumulator #(
  parameter int POINTS    = mbda_pkg::POINTS_DEF,
  parameter int BINS      = mbda_pkg::BINS_DEF,
  parameter int TRIG_BITS = mbda_pkg::TRIG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_vertex,
  input  logic [1:0]         in_bin_select,
  input  logic signed [31:0] in_sample,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  output logic signed [63:0] out_real_sum,
  output logic signed [63:0] out_imag_sum,
  output logic [9:0]         out_read_vertex,
  output logic [1:0]         out_read_bin,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH  = POINTS * BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  mbda_pkg::mbda_state_t   state_r, state_nxt;
  mbda_pkg::mbda_mul_sel_t mul_sel;

  logic [10:0] point_count_r;
  logic [2:0]  bin_count_r;
  logic [15:0] sample_count_r;
  logic [31:0] freq_r [4];

  logic [9:0]         vertex_r;
  logic [1:0]         b_r;
  logic signed [31:0] sample_r;
  logic [31:0]        time_r;
  logic [31:0]        phase_r;
  logic               cos_r;
  logic signed [32:0] s_r;
  logic signed [32:0] z2_r;
  logic signed [32:0] r_r;
  logic [1:0]         k_r;
  logic signed [15:0] c_r;
  logic signed [15:0] sn_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] pre_r;
  logic signed [63:0] re_q_r;
  logic [ADDR_W-1:0]  clr_r;

  logic [127:0] mem [DEPTH];
  logic [127:0] mem_rd_r;
  logic         mem_we;
  logic         mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [127:0] mem_wdata;

  logic               out_valid_r;
  logic signed [63:0] out_real_r;
  logic signed [63:0] out_imag_r;
  logic [9:0]         out_vertex_r;
  logic [1:0]         out_bin_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               in_fire;
  logic               vert_ok;
  logic               bsel_ok;
  logic               next_bin_ok;
  logic [2:0]         b_inc;
  logic [31:0]        idx32;
  logic [31:0]        angle;
  logic signed [32:0] s_raw, s_fold;
  logic signed [35:0] v_q30;
  logic signed [35:0] v_rnd;
  logic signed [15:0] trig;
  logic signed [32:0] horner;
  logic               div_start;
  logic signed [63:0] div_dividend;
  logic [15:0]        divisor;
  logic               div_done;
  logic signed [63:0] div_q;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign busy    = (state_r != mbda_pkg::ST_IDLE);
  assign in_fire = start && !busy;

  assign vert_ok = ({1'b0, in_vertex} < point_count_r) && (32'(in_vertex) < 32'(POINTS));
  assign bsel_ok = ({1'b0, in_bin_select} < bin_count_r) && (32'(in_bin_select) < 32'(BINS));
  assign b_inc   = {1'b0, b_r} + 3'd1;
  assign next_bin_ok = (b_inc < bin_count_r) && (32'(b_inc) < 32'(BINS));
  assign idx32    = 32'(vertex_r) * 32'(BINS) + 32'(b_r);
  assign divisor  = (sample_count_r == 16'd0) ? 16'd1 : sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r  <= mbda_pkg::POINT_COUNT_RST;
      bin_count_r    <= mbda_pkg::BIN_COUNT_RST;
      sample_count_r <= mbda_pkg::SAMPLE_COUNT_RST;
      for (int i = 0; i < 4; i++) begin
        freq_r[i] <= 32'd0;
      end
    end else if (cfg_we) begin
      case (paddr[4:2])
        mbda_pkg::REG_POINT_COUNT:  point_count_r  <= pwdata[10:0];
        mbda_pkg::REG_BIN_COUNT:    bin_count_r    <= pwdata[2:0];
        mbda_pkg::REG_SAMPLE_COUNT: sample_count_r <= pwdata[15:0];
        mbda_pkg::REG_FREQ_0:       freq_r[0]      <= pwdata;
        mbda_pkg::REG_FREQ_1:       freq_r[1]      <= pwdata;
        mbda_pkg::REG_FREQ_2:       freq_r[2]      <= pwdata;
        mbda_pkg::REG_FREQ_3:       freq_r[3]      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mbda_pkg::REG_POINT_COUNT:  prdata = {21'd0, point_count_r};
      mbda_pkg::REG_BIN_COUNT:    prdata = {29'd0, bin_count_r};
      mbda_pkg::REG_SAMPLE_COUNT: prdata = {16'd0, sample_count_r};
      mbda_pkg::REG_FREQ_0:       prdata = freq_r[0];
      mbda_pkg::REG_FREQ_1:       prdata = freq_r[1];
      mbda_pkg::REG_FREQ_2:       prdata = freq_r[2];
      mbda_pkg::REG_FREQ_3:       prdata = freq_r[3];
      default:                    prdata = 32'd0;
    endcase
  end

  // Quarter-wave fold of the phase taken as signed turns.
  always_comb begin
    angle = phase_r + (cos_r ? 32'h4000_0000 : 32'h0000_0000);
    s_raw = $signed({angle[31], angle});
    if (s_raw > 33'sd1073741824) begin
      s_fold = 33'sd2147483648 - s_raw;
    end else if (s_raw < -33'sd1073741824) begin
      s_fold = -33'sd2147483648 - s_raw;
    end else begin
      s_fold = s_raw;
    end
  end

  assign horner = mbda_pkg::sin_coef({1'b0, k_r}) - 33'(prod_r >>> 30);
  assign v_q30  = 36'(prod_r >>> 30);
  assign v_rnd  = (v_q30 + 36'sd16384) >>> 15;
  assign trig   = (v_rnd > 36'sd32767)  ? 16'sd32767 :
                  (v_rnd < -36'sd32768) ? -16'sd32768 : v_rnd[15:0];

  always_comb begin
    case (mul_sel)
      mbda_pkg::MUL_PHASE: begin
        mul_a = $signed({1'b0, freq_r[b_r]});
        mul_b = $signed({1'b0, time_r});
      end
      mbda_pkg::MUL_SQ: begin
        mul_a = s_r;
        mul_b = s_r;
      end
      mbda_pkg::MUL_HORNER: begin
        mul_a = z2_r;
        mul_b = r_r;
      end
      mbda_pkg::MUL_SR: begin
        mul_a = s_r;
        mul_b = r_r;
      end
      mbda_pkg::MUL_RE: begin
        mul_a = 33'(sample_r);
        mul_b = 33'(c_r);
      end
      mbda_pkg::MUL_IM: begin
        mul_a = 33'(sample_r);
        mul_b = 33'(sn_r);
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt    = state_r;
    mul_sel      = mbda_pkg::MUL_PHASE;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = idx32[ADDR_W-1:0];
    mem_wdata    = {mem_rd_r[127:64] + pre_r, mem_rd_r[63:0] - prod_r[63:0]};
    div_start    = 1'b0;
    div_dividend = $signed(mem_rd_r[127:64]);
    case (state_r)
      mbda_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = 128'd0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = mbda_pkg::ST_IDLE;
        end
      end
      mbda_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            mbda_pkg::OP_ACC: begin
              if (vert_ok && (bin_count_r != 3'd0)) begin
                state_nxt = mbda_pkg::ST_PHASE;
              end
            end
            mbda_pkg::OP_READ: begin
              if (vert_ok && bsel_ok) begin
                state_nxt = mbda_pkg::ST_RD;
              end
            end
            mbda_pkg::OP_CLEAR: state_nxt = mbda_pkg::ST_CLEAR;
            default: ;
          endcase
        end
      end
      mbda_pkg::ST_PHASE: begin
        mul_sel   = mbda_pkg::MUL_PHASE;
        state_nxt = mbda_pkg::ST_LATCH;
      end
      mbda_pkg::ST_LATCH: state_nxt = mbda_pkg::ST_FOLD;
      mbda_pkg::ST_FOLD:  state_nxt = mbda_pkg::ST_SQ;
      mbda_pkg::ST_SQ: begin
        mul_sel   = mbda_pkg::MUL_SQ;
        state_nxt = mbda_pkg::ST_Z2;
      end
      mbda_pkg::ST_Z2: state_nxt = mbda_pkg::ST_HMUL;
      mbda_pkg::ST_HMUL: begin
        mul_sel   = mbda_pkg::MUL_HORNER;
        state_nxt = mbda_pkg::ST_HACC;
      end
      mbda_pkg::ST_HACC: begin
        state_nxt = (k_r == 2'd0) ? mbda_pkg::ST_SR : mbda_pkg::ST_HMUL;
      end
      mbda_pkg::ST_SR: begin
        mul_sel   = mbda_pkg::MUL_SR;
        state_nxt = mbda_pkg::ST_ROUND;
      end
      mbda_pkg::ST_ROUND: begin
        state_nxt = cos_r ? mbda_pkg::ST_FOLD : mbda_pkg::ST_PRE;
      end
      mbda_pkg::ST_PRE: begin
        mul_sel   = mbda_pkg::MUL_RE;
        mem_re    = 1'b1;
        state_nxt = mbda_pkg::ST_PIM;
      end
      mbda_pkg::ST_PIM: begin
        mul_sel   = mbda_pkg::MUL_IM;
        state_nxt = mbda_pkg::ST_WRITE;
      end
      mbda_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = next_bin_ok ? mbda_pkg::ST_PHASE : mbda_pkg::ST_IDLE;
      end
      mbda_pkg::ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = mbda_pkg::ST_RDW;
      end
      mbda_pkg::ST_RDW: begin
        div_start = 1'b1;
        state_nxt = mbda_pkg::ST_DRE;
      end
      mbda_pkg::ST_DRE: begin
        div_dividend = $signed(mem_rd_r[63:0]);
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = mbda_pkg::ST_DIM;
        end
      end
      mbda_pkg::ST_DIM: begin
        if (div_done) begin
          state_nxt = mbda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbda_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      prod_r      <= mul_p;
      case (state_r)
        mbda_pkg::ST_CLEAR: clr_r <= clr_r + ADDR_W'(1);
        mbda_pkg::ST_IDLE: begin
          clr_r <= '0;
          if (in_fire) begin
            vertex_r <= in_vertex;
            sample_r <= in_sample;
            time_r   <= in_sample_time;
            b_r      <= (in_operation == mbda_pkg::OP_READ) ? in_bin_select : 2'd0;
            if ((in_operation == mbda_pkg::OP_READ) && !(vert_ok && bsel_ok)) begin
              out_valid_r  <= 1'b1;
              out_real_r   <= 64'sd0;
              out_imag_r   <= 64'sd0;
              out_vertex_r <= in_vertex;
              out_bin_r    <= in_bin_select;
            end
          end
        end
        mbda_pkg::ST_LATCH: begin
          phase_r <= prod_r[31:0] & KEEP_MASK;
          cos_r   <= 1'b1;
        end
        mbda_pkg::ST_FOLD: s_r <= s_fold;
        mbda_pkg::ST_Z2: begin
          z2_r <= 33'(prod_r >>> 30);
          r_r  <= mbda_pkg::sin_coef(3'd4);
          k_r  <= 2'd3;
        end
        mbda_pkg::ST_HACC: begin
          r_r <= horner;
          k_r <= k_r - 2'd1;
        end
        mbda_pkg::ST_ROUND: begin
          if (cos_r) begin
            c_r   <= trig;
            cos_r <= 1'b0;
          end else begin
            sn_r <= trig;
          end
        end
        mbda_pkg::ST_PIM:   pre_r <= prod_r[63:0];
        mbda_pkg::ST_WRITE: b_r   <= b_inc[1:0];
        mbda_pkg::ST_DRE: begin
          if (div_done) begin
            re_q_r <= div_q;
          end
        end
        mbda_pkg::ST_DIM: begin
          if (div_done) begin
            out_valid_r  <= 1'b1;
            out_real_r   <= re_q_r;
            out_imag_r   <= div_q;
            out_vertex_r <= vertex_r;
            out_bin_r    <= b_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_addr];
    end
  end

  mbda_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid       = out_valid_r;
  assign out_real_sum    = out_real_r;
  assign out_imag_sum    = out_imag_r;
  assign out_read_vertex = out_vertex_r;
  assign out_read_bin    = out_bin_r;

endmodule

[rtl/core/mbda_divider.sv]
// Bit-serial signed 64-bit by unsigned 16-bit divider, one quotient bit per cycle.
// Truncates toward zero; uses no package items.
module mbda_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic        run_r;
  logic        done_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic [63:0] mag_r;
  logic [15:0] rem_r;
  logic [15:0] div_r;
  logic [16:0] rem_sh;
  logic [17:0] trial;
  logic [63:0] mag_nxt;
  logic [15:0] rem_nxt;
  logic [63:0] abs_in;

  assign abs_in = dividend[63] ? (64'd0 - dividend) : dividend;
  assign rem_sh = {rem_r, mag_r[63]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_r};

  always_comb begin
    if (!trial[17]) begin
      rem_nxt = trial[15:0];
      mag_nxt = {mag_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[15:0];
      mag_nxt = {mag_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd0;
        neg_r <= dividend[63];
        mag_r <= abs_in;
        rem_r <= 16'd0;
        div_r <= divisor;
      end else if (run_r) begin
        mag_r <= mag_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (64'sd0 - $signed(mag_r)) : $signed(mag_r);

endmodule

[rtl/core/mbda_checker.sv]
// Port-level checks of the multi-bin DFT accumulator, bound to the top level.
// Depends on mbda_pkg for operation codes.
module mbda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        pready
);

  // The store is swept after reset before any beat is taken.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
      (start && !busy && (in_operation == mbda_pkg::OP_CLEAR)) |=> busy)
    else $error("clear beat did not start a sweep");

  a_acc_silent: assert property (@(posedge clk) disable iff (!rst_n)
      (start && !busy && (in_operation == mbda_pkg::OP_ACC)) |=> !out_valid)
    else $error("accumulate beat produced a result");

endmodule

bind multi_bin_dft_accumulator mbda_checker u_mbda_checker (.*);
